### hw/rtl/pec_pkg.sv
package pec_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int RES_DEPTH    = 32;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int VCNT_W       = $clog2(MAX_VERTICES + 1);
    localparam int RIDX_W       = $clog2(RES_DEPTH);
    localparam int RCNT_W       = $clog2(RES_DEPTH + 1);
    localparam int AMT_W        = 31;
    localparam int DIV_STEPS    = 30;
    localparam int DCNT_W       = $clog2(DIV_STEPS + 1);
    localparam logic [AMT_W-1:0] AMT_ONE = AMT_W'(1) << DIV_STEPS;

    // Configuration register indexes
    localparam logic REG_CLIP_LEVEL = 1'b0;
    localparam logic REG_KEEP_ABOVE = 1'b1;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] e;
        logic [16:0]        p;
    } t_vert;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RD_PREV,
        OP_LATCH_PREV,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_MUL_X,
        OP_MUL_Y,
        OP_MUL_P,
        OP_KEEP_CROSS,
        OP_STEP,
        OP_TRIM,
        OP_EMIT_RD,
        OP_EMIT_LD,
        OP_EMIT_NEXT
    } t_op;

    typedef struct packed {
        logic n_zero;
        logic cur_in;
        logic prev_in;
        logic div_busy;
        logic last_step;
        logic out_last;
    } t_stat;

endpackage

### hw/rtl/pec_if.sv
interface pec_vert_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_elevation;
    logic [16:0]        vert_param;
    logic               last_vertex;

    modport source (output valid, vert_x, vert_y, vert_elevation, vert_param, last_vertex,
                    input ready);
    modport sink   (input valid, vert_x, vert_y, vert_elevation, vert_param, last_vertex,
                    output ready);
endinterface

interface pec_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_elevation;
    logic [16:0]        out_param;
    logic               run_last;
    logic               empty_polygon;
    logic               overflowed;

    modport source (output valid, out_x, out_y, out_elevation, out_param, run_last,
                    empty_polygon, overflowed, input ready);
    modport sink   (input valid, out_x, out_y, out_elevation, out_param, run_last,
                    empty_polygon, overflowed, output ready);
endinterface

### hw/rtl/pec_ctrl.sv
module pec_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_last,
    input  logic           i_out_ready,
    input  pec_pkg::t_stat i_stat,
    output pec_pkg::t_op   o_op,
    output logic           o_in_ready
);

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_PREV, S_CUR, S_DIV, S_MY, S_MP, S_KC, S_ST,
        S_TRIM, S_ERD, S_ELD, S_EW
    } t_state;

    t_state r_state, n_state;

    // Decode command and next state
    always_comb begin
        n_state = r_state;
        o_op    = pec_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op = pec_pkg::OP_LOAD;
                    if (i_in_last) n_state = S_START;
                end
            end
            S_START: begin
                o_op    = pec_pkg::OP_RD_PREV;
                n_state = i_stat.n_zero ? S_ELD : S_PREV;
            end
            S_PREV: begin
                o_op    = pec_pkg::OP_LATCH_PREV;
                n_state = S_CUR;
            end
            S_CUR: begin
                if (i_stat.cur_in != i_stat.prev_in) begin
                    o_op    = pec_pkg::OP_DIV_INIT;
                    n_state = S_DIV;
                end else begin
                    o_op    = pec_pkg::OP_STEP;
                    n_state = i_stat.last_step ? S_TRIM : S_CUR;
                end
            end
            S_DIV: begin
                if (i_stat.div_busy) begin
                    o_op = pec_pkg::OP_DIV_STEP;
                end else begin
                    o_op    = pec_pkg::OP_MUL_X;
                    n_state = S_MY;
                end
            end
            S_MY: begin
                o_op    = pec_pkg::OP_MUL_Y;
                n_state = S_MP;
            end
            S_MP: begin
                o_op    = pec_pkg::OP_MUL_P;
                n_state = S_KC;
            end
            S_KC: begin
                o_op    = pec_pkg::OP_KEEP_CROSS;
                n_state = S_ST;
            end
            S_ST: begin
                o_op    = pec_pkg::OP_STEP;
                n_state = i_stat.last_step ? S_TRIM : S_CUR;
            end
            S_TRIM: begin
                o_op    = pec_pkg::OP_TRIM;
                n_state = S_ERD;
            end
            S_ERD: begin
                o_op    = pec_pkg::OP_EMIT_RD;
                n_state = S_ELD;
            end
            S_ELD: begin
                o_op    = pec_pkg::OP_EMIT_LD;
                n_state = S_EW;
            end
            S_EW: begin
                if (i_out_ready) begin
                    o_op    = pec_pkg::OP_EMIT_NEXT;
                    n_state = i_stat.out_last ? S_IDLE : S_ERD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hw/rtl/pec_dpath.sv
module pec_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pec_pkg::t_op       i_op,
    input  logic signed [31:0] i_level,
    input  logic               i_keep_above,
    input  pec_pkg::t_vert     i_in_vert,
    output pec_pkg::t_stat     o_stat,
    output pec_pkg::t_vert     o_res,
    output logic               o_res_valid,
    output logic               o_run_last,
    output logic               o_empty,
    output logic               o_ovf
);

    // Vertex store and result store
    pec_pkg::t_vert r_st_mem  [pec_pkg::MAX_VERTICES];
    pec_pkg::t_vert r_res_mem [pec_pkg::RES_DEPTH];
    pec_pkg::t_vert r_st_rd, r_res_rd, r_prev, r_first, r_last;
    logic           r_prev_in;

    logic [pec_pkg::VCNT_W-1:0] r_ld_cnt, r_idx;
    logic [pec_pkg::RCNT_W-1:0] r_cnt, r_ek;
    logic                       r_ovf;

    // Divider
    logic [32:0]                r_rem, r_den;
    logic [pec_pkg::AMT_W-1:0]  r_quo;
    logic [pec_pkg::DCNT_W-1:0] r_dcnt;

    // Blended crossing vertex
    logic signed [31:0] r_bx, r_by;
    logic [16:0]        r_bp;

    // Output register
    pec_pkg::t_vert r_o;
    logic           r_o_valid, r_o_last, r_o_empty;

    logic cur_in;
    assign cur_in = i_keep_above ? (r_st_rd.e >= i_level) : (r_st_rd.e <= i_level);

    logic [pec_pkg::VCNT_W-1:0] ld_dec, idx_nx;
    logic [pec_pkg::RCNT_W-1:0] ek_nx, cnt_dec;
    assign ld_dec  = r_ld_cnt - 1'b1;
    assign idx_nx  = r_idx + 1'b1;
    assign ek_nx   = r_ek + 1'b1;
    assign cnt_dec = r_cnt - 1'b1;

    // Division setup: magnitudes and the cases that give amount zero or one
    logic signed [32:0] num, den;
    logic [32:0]        un, ud;
    logic               div_zero;
    always_comb begin
        num = {i_level[31], i_level} - {r_prev.e[31], r_prev.e};
        den = {r_st_rd.e[31], r_st_rd.e} - {r_prev.e[31], r_prev.e};
        un  = num[32] ? (~num + 33'd1) : num;
        ud  = den[32] ? (~den + 33'd1) : den;
        div_zero = (den == '0)
                || (num[32] && !den[32] && den != '0)
                || (!num[32] && num != '0 && den[32]);
    end

    // One restoring division step
    logic [33:0] r2, r2_sub;
    logic        r2_ge;
    assign r2     = {r_rem, 1'b0};
    assign r2_sub = r2 - {1'b0, r_den};
    assign r2_ge  = (r2 >= {1'b0, r_den});

    // Blend a + sign(b - a) * floor(|b - a| * amount / 2^30)
    logic signed [32:0] ma, mb;
    logic signed [33:0] mdiff;
    logic [32:0]        mmag;
    logic [63:0]        mprod;
    logic [33:0]        mpart;
    logic signed [33:0] mres;
    always_comb begin
        unique case (i_op)
            pec_pkg::OP_MUL_X: begin
                ma = {r_prev.x[31], r_prev.x};
                mb = {r_st_rd.x[31], r_st_rd.x};
            end
            pec_pkg::OP_MUL_Y: begin
                ma = {r_prev.y[31], r_prev.y};
                mb = {r_st_rd.y[31], r_st_rd.y};
            end
            default: begin
                ma = {16'd0, r_prev.p};
                mb = {16'd0, r_st_rd.p};
            end
        endcase
        mdiff = {mb[32], mb} - {ma[32], ma};
        mmag  = mdiff[33] ? 33'(~mdiff + 34'd1) : mdiff[32:0];
        mprod = 64'(mmag) * 64'(r_quo);
        mpart = mprod[63:30];
        mres  = mdiff[33] ? ({ma[32], ma} - $signed(mpart)) : ({ma[32], ma} + $signed(mpart));
    end

    // Candidate kept vertex and its duplicate check
    pec_pkg::t_vert keep_v;
    logic           keep_en, keep_dup, trim_dup;
    always_comb begin
        keep_v   = r_st_rd;
        keep_en  = 1'b0;
        if (i_op == pec_pkg::OP_KEEP_CROSS) begin
            keep_v  = '{x: r_bx, y: r_by, e: i_level, p: r_bp};
            keep_en = 1'b1;
        end else if (i_op == pec_pkg::OP_STEP) begin
            keep_en = cur_in;
        end
        keep_dup = (r_cnt != '0) && (r_last.x == keep_v.x) && (r_last.y == keep_v.y)
                && (r_last.e == keep_v.e);
        trim_dup = (r_cnt > pec_pkg::RCNT_W'(1)) && (r_first.x == r_last.x)
                && (r_first.y == r_last.y) && (r_first.e == r_last.e);
    end

    // Memories
    always_ff @(posedge i_clk) begin
        if (i_op == pec_pkg::OP_LOAD && r_ld_cnt < pec_pkg::VCNT_W'(pec_pkg::MAX_VERTICES)) begin
            r_st_mem[r_ld_cnt[pec_pkg::VIDX_W-1:0]] <= i_in_vert;
        end
        if (i_op == pec_pkg::OP_RD_PREV) begin
            r_st_rd <= r_st_mem[ld_dec[pec_pkg::VIDX_W-1:0]];
        end else if (i_op == pec_pkg::OP_LATCH_PREV) begin
            r_st_rd <= r_st_mem[0];
        end else if (i_op == pec_pkg::OP_STEP) begin
            r_st_rd <= r_st_mem[idx_nx[pec_pkg::VIDX_W-1:0]];
        end
        if (keep_en && !keep_dup && r_cnt < pec_pkg::RCNT_W'(pec_pkg::RES_DEPTH)) begin
            r_res_mem[r_cnt[pec_pkg::RIDX_W-1:0]] <= keep_v;
        end
        if (i_op == pec_pkg::OP_EMIT_RD) begin
            r_res_rd <= r_res_mem[r_ek[pec_pkg::RIDX_W-1:0]];
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_op == pec_pkg::OP_LATCH_PREV || i_op == pec_pkg::OP_STEP) begin
            r_prev    <= r_st_rd;
            r_prev_in <= cur_in;
        end
        if (keep_en && !keep_dup && r_cnt < pec_pkg::RCNT_W'(pec_pkg::RES_DEPTH)) begin
            r_last <= keep_v;
            if (r_cnt == '0) r_first <= keep_v;
        end
        if (i_op == pec_pkg::OP_DIV_INIT) begin
            r_rem <= un;
            r_den <= ud;
        end else if (i_op == pec_pkg::OP_DIV_STEP) begin
            r_rem <= r2_ge ? r2_sub[32:0] : r2[32:0];
        end
        if (i_op == pec_pkg::OP_MUL_X) r_bx <= mres[31:0];
        if (i_op == pec_pkg::OP_MUL_Y) r_by <= mres[31:0];
        if (i_op == pec_pkg::OP_MUL_P) r_bp <= mres[16:0];
        if (i_op == pec_pkg::OP_DIV_INIT) begin
            if (div_zero)      r_quo <= '0;
            else if (un >= ud) r_quo <= pec_pkg::AMT_ONE;
            else               r_quo <= '0;
        end else if (i_op == pec_pkg::OP_DIV_STEP) begin
            r_quo <= {r_quo[pec_pkg::AMT_W-2:0], r2_ge};
        end
        if (i_op == pec_pkg::OP_EMIT_LD) begin
            if (r_cnt == '0) begin
                r_o       <= '0;
                r_o_last  <= 1'b1;
                r_o_empty <= 1'b1;
            end else begin
                r_o       <= r_res_rd;
                r_o_last  <= (ek_nx == r_cnt);
                r_o_empty <= 1'b0;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld_cnt  <= '0;
            r_idx     <= '0;
            r_cnt     <= '0;
            r_ek      <= '0;
            r_ovf     <= 1'b0;
            r_dcnt    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            unique case (i_op)
                pec_pkg::OP_LOAD: begin
                    if (r_ld_cnt < pec_pkg::VCNT_W'(pec_pkg::MAX_VERTICES)) r_ld_cnt <= r_ld_cnt + 1'b1;
                    else                                                     r_ovf    <= 1'b1;
                end
                pec_pkg::OP_RD_PREV: begin
                    r_cnt <= '0;
                    r_ek  <= '0;
                end
                pec_pkg::OP_LATCH_PREV: r_idx <= '0;
                pec_pkg::OP_DIV_INIT: begin
                    r_dcnt <= (div_zero || un >= ud) ? '0 : pec_pkg::DCNT_W'(pec_pkg::DIV_STEPS);
                end
                pec_pkg::OP_DIV_STEP: r_dcnt <= r_dcnt - 1'b1;
                pec_pkg::OP_TRIM: begin
                    if (trim_dup) r_cnt <= cnt_dec;
                end
                pec_pkg::OP_EMIT_LD: r_o_valid <= 1'b1;
                pec_pkg::OP_EMIT_NEXT: begin
                    r_o_valid <= 1'b0;
                    r_ek      <= ek_nx;
                    if (r_o_last) begin
                        r_ld_cnt <= '0;
                        r_ovf    <= 1'b0;
                    end
                end
                default: ;
            endcase
            if (i_op == pec_pkg::OP_STEP) r_idx <= idx_nx;
            // Count a kept vertex, or flag a full result store
            if (keep_en && !keep_dup) begin
                if (r_cnt < pec_pkg::RCNT_W'(pec_pkg::RES_DEPTH)) r_cnt <= r_cnt + 1'b1;
                else                                              r_ovf <= 1'b1;
            end
        end
    end

    assign o_stat = '{n_zero:    (r_ld_cnt == '0),
                      cur_in:    cur_in,
                      prev_in:   r_prev_in,
                      div_busy:  (r_dcnt != '0),
                      last_step: (idx_nx == r_ld_cnt),
                      out_last:  r_o_last};

    assign o_res       = r_o;
    assign o_res_valid = r_o_valid;
    assign o_run_last  = r_o_last;
    assign o_empty     = r_o_empty;
    assign o_ovf       = r_ovf;

endmodule

### hw/rtl/polygon_elevation_clipper_unit.sv
// Vertex load: one item per cycle while idle; an item without last_vertex gives no result.
// Clip pass after the last vertex: setup reads the last and first stored vertices, then each stored
// vertex is tested in turn; an edge that crosses the plane runs a 30-step serial divider (skipped when
// the amount is zero or one) and 3 blend multiplies; a trim step then drops a closing duplicate.
// Emit: each result item is read, loaded and held until taken; new vertices wait until the last is taken.
// Reset (i_rst_n low, synchronous): counts, overflow and valid flags cleared, clip_level 0, keep_above 1;
// vertex and result memories are not cleared.
module polygon_elevation_clipper_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready,
    pec_vert_if.sink    i_in,
    pec_res_if.source   o_out
);

    logic signed [31:0] r_clip_level;
    logic               r_keep_above;
    logic               cfg_wr;

    // Configuration registers
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_level <= '0;
            r_keep_above <= 1'b1;
        end else if (cfg_wr) begin
            unique case (i_paddr[2])
                pec_pkg::REG_CLIP_LEVEL: r_clip_level <= i_pwdata;
                pec_pkg::REG_KEEP_ABOVE: r_keep_above <= i_pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (i_paddr[2])
            pec_pkg::REG_CLIP_LEVEL: o_prdata = r_clip_level;
            pec_pkg::REG_KEEP_ABOVE: o_prdata = {31'd0, r_keep_above};
            default:                 o_prdata = '0;
        endcase
    end

    pec_pkg::t_op   op;
    pec_pkg::t_stat stat;
    pec_pkg::t_vert in_vert, res;
    logic           in_ready;

    assign in_vert = '{x: i_in.vert_x, y: i_in.vert_y, e: i_in.vert_elevation,
                       p: i_in.vert_param};
    assign i_in.ready = in_ready;

    pec_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_last   (i_in.last_vertex),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_op        (op),
        .o_in_ready  (in_ready)
    );

    pec_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (op),
        .i_level      (r_clip_level),
        .i_keep_above (r_keep_above),
        .i_in_vert    (in_vert),
        .o_stat       (stat),
        .o_res        (res),
        .o_res_valid  (o_out.valid),
        .o_run_last   (o_out.run_last),
        .o_empty      (o_out.empty_polygon),
        .o_ovf        (o_out.overflowed)
    );

    // Drive result payload
    assign o_out.out_x         = res.x;
    assign o_out.out_y         = res.y;
    assign o_out.out_elevation = res.e;
    assign o_out.out_param     = res.p;

endmodule
